// ===== sv/sms_pkg.sv =====
// ----------------------------------------------------------------------------
// Stepper move sequencer package
// Shared item codes, field widths and the result record.
// ----------------------------------------------------------------------------
package sms_pkg;

    localparam int KIND_W   = 3;
    localparam int STEPS_W  = 24;
    localparam int PERIOD_W = 20;
    localparam int HALF_W   = STEPS_W + 1;
    localparam int OUTC_W   = 2;

    localparam logic [KIND_W-1:0] KIND_START = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TICK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RIGHT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LEFT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ESTOP = 3'd4;

    localparam logic [OUTC_W-1:0] OUT_FINISHED = 2'd0;
    localparam logic [OUTC_W-1:0] OUT_RIGHT    = 2'd1;
    localparam logic [OUTC_W-1:0] OUT_LEFT     = 2'd2;
    localparam logic [OUTC_W-1:0] OUT_ESTOP    = 2'd3;

    typedef struct packed {
        logic              step_level;
        logic              dir_level;
        logic              enable_n;
        logic              busy_res;
        logic              done_res;
        logic [OUTC_W-1:0] outcome;
    } result_t;

endpackage

// ===== sv/sms_core.sv =====
// ----------------------------------------------------------------------------
// Stepper move sequencer core
// Move state, tick divider and half-step counter, updated once per transfer.
// ----------------------------------------------------------------------------
module sms_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic                         cfg_wdata,
    input  logic                         accept,
    input  logic [sms_pkg::KIND_W-1:0]   kind,
    input  logic                         direction,
    input  logic [sms_pkg::STEPS_W-1:0]  step_count,
    input  logic [sms_pkg::PERIOD_W-1:0] half_period,
    input  logic                         right_limit_level,
    input  logic                         left_limit_level,
    output sms_pkg::result_t             result
);

    logic                         right_is_dir_high_reg;
    logic                         moving_reg, moving_next;
    logic                         move_dir_reg, move_dir_next;
    logic [sms_pkg::HALF_W-1:0]   half_left_reg, half_left_next;
    logic [sms_pkg::PERIOD_W-1:0] tick_cnt_reg, tick_cnt_next;
    logic [sms_pkg::PERIOD_W-1:0] period_reg, period_next;
    logic                         step_out_reg, step_out_next;
    logic                         dir_out_reg, dir_out_next;
    logic [sms_pkg::OUTC_W-1:0]   outcome_reg, outcome_next;

    logic                         finish;
    logic [sms_pkg::OUTC_W-1:0]   finish_code;
    logic [sms_pkg::PERIOD_W-1:0] tick_inc;
    logic [sms_pkg::HALF_W-1:0]   half_dec;

    assign tick_inc = tick_cnt_reg + {{(sms_pkg::PERIOD_W-1){1'b0}}, 1'b1};
    assign half_dec = half_left_reg - {{(sms_pkg::HALF_W-1){1'b0}}, 1'b1};

    always_comb begin
        moving_next    = moving_reg;
        move_dir_next  = move_dir_reg;
        half_left_next = half_left_reg;
        tick_cnt_next  = tick_cnt_reg;
        period_next    = period_reg;
        step_out_next  = step_out_reg;
        dir_out_next   = dir_out_reg;
        finish         = 1'b0;
        finish_code    = sms_pkg::OUT_FINISHED;

        if (!moving_reg) begin
            if (kind == sms_pkg::KIND_START) begin
                if (right_limit_level && direction) begin
                    finish      = 1'b1;
                    finish_code = sms_pkg::OUT_RIGHT;
                end else if (left_limit_level && !direction) begin
                    finish      = 1'b1;
                    finish_code = sms_pkg::OUT_LEFT;
                end else begin
                    move_dir_next  = direction;
                    dir_out_next   = ~(right_is_dir_high_reg ^ direction);
                    step_out_next  = 1'b0;
                    tick_cnt_next  = '0;
                    period_next    = (half_period == '0) ?
                                     {{(sms_pkg::PERIOD_W-1){1'b0}}, 1'b1} : half_period;
                    half_left_next = {step_count, 1'b0};
                    if (step_count == '0) begin
                        finish      = 1'b1;
                        finish_code = sms_pkg::OUT_FINISHED;
                    end else begin
                        moving_next = 1'b1;
                    end
                end
            end
        end else begin
            case (kind)
                sms_pkg::KIND_TICK: begin
                    tick_cnt_next = tick_inc;
                    if (tick_inc >= period_reg) begin
                        tick_cnt_next  = '0;
                        half_left_next = half_dec;
                        step_out_next  = half_dec[0];
                        if (half_dec == '0) begin
                            finish      = 1'b1;
                            finish_code = sms_pkg::OUT_FINISHED;
                        end
                    end
                end
                sms_pkg::KIND_RIGHT: begin
                    if (right_limit_level && move_dir_reg) begin
                        finish      = 1'b1;
                        finish_code = sms_pkg::OUT_RIGHT;
                    end
                end
                sms_pkg::KIND_LEFT: begin
                    if (left_limit_level && !move_dir_reg) begin
                        finish      = 1'b1;
                        finish_code = sms_pkg::OUT_LEFT;
                    end
                end
                sms_pkg::KIND_ESTOP: begin
                    finish      = 1'b1;
                    finish_code = sms_pkg::OUT_ESTOP;
                end
                default: begin
                end
            endcase
        end

        outcome_next = outcome_reg;
        if (finish) begin
            moving_next    = 1'b0;
            step_out_next  = 1'b0;
            half_left_next = '0;
            tick_cnt_next  = '0;
            outcome_next   = finish_code;
        end

        result.step_level = step_out_next;
        result.dir_level  = dir_out_next;
        result.enable_n   = ~moving_next;
        result.busy_res   = moving_next;
        result.done_res   = finish;
        result.outcome    = outcome_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            right_is_dir_high_reg <= 1'b1;
            moving_reg            <= 1'b0;
            move_dir_reg          <= 1'b0;
            half_left_reg         <= '0;
            tick_cnt_reg          <= '0;
            period_reg            <= {{(sms_pkg::PERIOD_W-1){1'b0}}, 1'b1};
            step_out_reg          <= 1'b0;
            dir_out_reg           <= 1'b0;
            outcome_reg           <= sms_pkg::OUT_FINISHED;
        end else begin
            if (cfg_we) begin
                right_is_dir_high_reg <= cfg_wdata;
            end
            if (accept) begin
                moving_reg    <= moving_next;
                move_dir_reg  <= move_dir_next;
                half_left_reg <= half_left_next;
                tick_cnt_reg  <= tick_cnt_next;
                period_reg    <= period_next;
                step_out_reg  <= step_out_next;
                dir_out_reg   <= dir_out_next;
                outcome_reg   <= outcome_next;
            end
        end
    end

endmodule

// ===== sv/sms_out_reg.sv =====
// ----------------------------------------------------------------------------
// Stepper move sequencer result register
// Holds one result until its transfer and accepts a new item in the same cycle.
// ----------------------------------------------------------------------------
module sms_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  sms_pkg::result_t in_result,
    output logic             out_valid,
    input  logic             out_ready,
    output sms_pkg::result_t out_result
);

    logic             valid_reg;
    sms_pkg::result_t result_reg;

    assign in_ready   = ~valid_reg | out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            result_reg <= in_result;
        end
    end

endmodule

// ===== sv/stepper_move_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// Stepper move sequencer top level
// Step/direction move control driven by start, tick, limit and stop items.
// ----------------------------------------------------------------------------
// Items enter on the s_ channel with valid/ready. Each transfer yields exactly
// one result on the m_ channel carrying the step, direction and enable pin
// levels, the busy and done flags and the outcome of the last finished move.
// A result is registered and appears in the cycle after its item is taken. The
// block takes one item per cycle unless the receiver stalls, and the single
// result register sets that rate. A start refused by an active limit switch,
// or one with zero steps, ends on the same item with the done flag set.
// cfg_wdata sets the direction pin polarity register, written with cfg_we;
// the user must write it while no move is running; the block does not check.
// Synchronous reset clears the move state, empties the result register and
// sets the polarity to drive the direction pin high for right moves.
// When the receiver stalls, the held result stays in place and s_ready drops
// until the result transfer completes; no item is lost or repeated.
// ----------------------------------------------------------------------------
module stepper_move_sequencer_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic                         cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [sms_pkg::KIND_W-1:0]   s_kind,
    input  logic                         s_direction,
    input  logic [sms_pkg::STEPS_W-1:0]  s_step_count,
    input  logic [sms_pkg::PERIOD_W-1:0] s_half_period,
    input  logic                         s_right_limit_level,
    input  logic                         s_left_limit_level,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_step_level,
    output logic                         m_dir_level,
    output logic                         m_enable_n,
    output logic                         m_busy_res,
    output logic                         m_done_res,
    output logic [sms_pkg::OUTC_W-1:0]   m_outcome
);

    sms_pkg::result_t core_result;
    sms_pkg::result_t out_result;
    logic             accept;

    assign accept = s_valid & s_ready;

    sms_core u_core (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .accept            (accept),
        .kind              (s_kind),
        .direction         (s_direction),
        .step_count        (s_step_count),
        .half_period       (s_half_period),
        .right_limit_level (s_right_limit_level),
        .left_limit_level  (s_left_limit_level),
        .result            (core_result)
    );

    sms_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_result  (core_result),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_result (out_result)
    );

    assign m_step_level = out_result.step_level;
    assign m_dir_level  = out_result.dir_level;
    assign m_enable_n   = out_result.enable_n;
    assign m_busy_res   = out_result.busy_res;
    assign m_done_res   = out_result.done_res;
    assign m_outcome    = out_result.outcome;

endmodule

// ===== sv/sms_checker.sv =====
// ----------------------------------------------------------------------------
// Stepper move sequencer checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module sms_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic                       m_step_level,
    input logic                       m_enable_n,
    input logic                       m_busy_res,
    input logic                       m_done_res,
    input logic [sms_pkg::OUTC_W-1:0] m_outcome
);

    a_enable_matches_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_enable_n == ~m_busy_res))
        else $error("Driver enable does not match the busy flag.");

    a_step_low_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_busy_res) |-> !m_step_level)
        else $error("Step pin is high while no move is running.");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_done_res) |-> !m_busy_res)
        else $error("A result marks a finished move but still reports busy.");

    a_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid right after reset.");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_outcome) && $stable(m_done_res)))
        else $error("Stalled result changed before its transfer.");

endmodule

bind stepper_move_sequencer_top sms_checker u_sms_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_step_level (m_step_level),
    .m_enable_n   (m_enable_n),
    .m_busy_res   (m_busy_res),
    .m_done_res   (m_done_res),
    .m_outcome    (m_outcome)
);

// ===== sim/stepper_move_sequencer_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stepper move sequencer testbench
// Sends start, tick, limit and stop items, predicts the pin levels and flags
// after every transfer, and compares each result in order. Random phases run
// with and without idle cycles, a long output hold-off and both polarities.
// ----------------------------------------------------------------------------
module stepper_move_sequencer_top_tb;

    localparam logic [sms_pkg::KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [sms_pkg::KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 150;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         cfg_we = 1'b0;
    logic                         cfg_wdata = 1'b1;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic [sms_pkg::KIND_W-1:0]   s_kind = sms_pkg::KIND_TICK;
    logic                         s_direction = 1'b0;
    logic [sms_pkg::STEPS_W-1:0]  s_step_count = '0;
    logic [sms_pkg::PERIOD_W-1:0] s_half_period = '0;
    logic                         s_right_limit_level = 1'b0;
    logic                         s_left_limit_level = 1'b0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic                         m_step_level;
    logic                         m_dir_level;
    logic                         m_enable_n;
    logic                         m_busy_res;
    logic                         m_done_res;
    logic [sms_pkg::OUTC_W-1:0]   m_outcome;

    // Predicted move state and polarity.
    logic                         mv_active = 1'b0;
    logic                         mv_dir = 1'b0;
    logic [sms_pkg::HALF_W-1:0]   mv_half_left = '0;
    logic [sms_pkg::PERIOD_W-1:0] mv_ticks = '0;
    logic [sms_pkg::PERIOD_W-1:0] mv_period = 20'd1;
    logic                         pin_step = 1'b0;
    logic                         pin_dir = 1'b0;
    logic [sms_pkg::OUTC_W-1:0]   last_code = sms_pkg::OUT_FINISHED;
    logic                         pol_right_high = 1'b1;

    sms_pkg::result_t expected_pins[$];
    sms_pkg::result_t want_pins;
    sms_pkg::result_t got_pins;

    int error_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int moves_ended[4] = '{0, 0, 0, 0};
    int quiet_cycles = 0;
    int tx_idle_pct = 35;
    int rx_idle_pct = 35;
    int rx_hold_req = 0;
    int rx_hold_left = 0;

    stepper_move_sequencer_top i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_kind              (s_kind),
        .s_direction         (s_direction),
        .s_step_count        (s_step_count),
        .s_half_period       (s_half_period),
        .s_right_limit_level (s_right_limit_level),
        .s_left_limit_level  (s_left_limit_level),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_step_level        (m_step_level),
        .m_dir_level         (m_dir_level),
        .m_enable_n          (m_enable_n),
        .m_busy_res          (m_busy_res),
        .m_done_res          (m_done_res),
        .m_outcome           (m_outcome)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic void close_move(input logic [sms_pkg::OUTC_W-1:0] code);
        mv_active = 1'b0;
        pin_step = 1'b0;
        mv_half_left = '0;
        mv_ticks = '0;
        last_code = code;
    endfunction

    function automatic sms_pkg::result_t advance_sequencer(
        input logic [sms_pkg::KIND_W-1:0]   kind,
        input logic                         dir,
        input logic [sms_pkg::STEPS_W-1:0]  steps,
        input logic [sms_pkg::PERIOD_W-1:0] half,
        input logic                         rlim,
        input logic                         llim
    );
        sms_pkg::result_t pins;
        logic             ended;
        ended = 1'b0;
        if (!mv_active) begin
            if (kind == sms_pkg::KIND_START) begin
                if (rlim && dir) begin
                    close_move(sms_pkg::OUT_RIGHT);
                    ended = 1'b1;
                end else if (llim && !dir) begin
                    close_move(sms_pkg::OUT_LEFT);
                    ended = 1'b1;
                end else begin
                    mv_dir = dir;
                    pin_dir = ~(pol_right_high ^ dir);
                    pin_step = 1'b0;
                    mv_ticks = '0;
                    mv_period = (half == '0) ? 20'd1 : half;
                    mv_half_left = {steps, 1'b0};
                    if (mv_half_left == '0) begin
                        close_move(sms_pkg::OUT_FINISHED);
                        ended = 1'b1;
                    end else begin
                        mv_active = 1'b1;
                    end
                end
            end
        end else begin
            case (kind)
                sms_pkg::KIND_TICK: begin
                    mv_ticks = mv_ticks + 1'b1;
                    if (mv_ticks >= mv_period) begin
                        mv_ticks = '0;
                        mv_half_left = mv_half_left - 1'b1;
                        pin_step = mv_half_left[0];
                        if (mv_half_left == '0) begin
                            close_move(sms_pkg::OUT_FINISHED);
                            ended = 1'b1;
                        end
                    end
                end
                sms_pkg::KIND_RIGHT: begin
                    if (rlim && mv_dir) begin
                        close_move(sms_pkg::OUT_RIGHT);
                        ended = 1'b1;
                    end
                end
                sms_pkg::KIND_LEFT: begin
                    if (llim && !mv_dir) begin
                        close_move(sms_pkg::OUT_LEFT);
                        ended = 1'b1;
                    end
                end
                sms_pkg::KIND_ESTOP: begin
                    close_move(sms_pkg::OUT_ESTOP);
                    ended = 1'b1;
                end
                default: begin
                end
            endcase
        end
        pins.step_level = pin_step;
        pins.dir_level  = pin_dir;
        pins.enable_n   = ~mv_active;
        pins.busy_res   = mv_active;
        pins.done_res   = ended;
        pins.outcome    = last_code;
        return pins;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t, result %0d, %s: got %0d, expected %0d",
                 $realtime, results_seen, what, got, want);
        error_count++;
    endtask

    task automatic send_item(
        input logic [sms_pkg::KIND_W-1:0]   kind,
        input logic                         dir,
        input logic [sms_pkg::STEPS_W-1:0]  steps,
        input logic [sms_pkg::PERIOD_W-1:0] half,
        input logic                         rlim,
        input logic                         llim
    );
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_kind              <= kind;
        s_direction         <= dir;
        s_step_count        <= steps;
        s_half_period       <= half;
        s_right_limit_level <= rlim;
        s_left_limit_level  <= llim;
        do @(posedge aclk); while (s_ready !== 1'b1);
        expected_pins.push_back(advance_sequencer(kind, dir, steps, half, rlim, llim));
        items_sent++;
    endtask

    task automatic wait_for_results;
        s_valid <= 1'b0;
        while (expected_pins.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_polarity(input logic right_high);
        if (mv_active) begin
            send_item(sms_pkg::KIND_ESTOP, 1'b0, '0, '0, 1'b0, 1'b0);
        end
        wait_for_results();
        repeat (3) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= right_high;
        @(posedge aclk);
        cfg_we <= 1'b0;
        pol_right_high = right_high;
    endtask

    task automatic send_random_item;
        logic [sms_pkg::KIND_W-1:0]   kind;
        logic                         dir;
        logic [sms_pkg::STEPS_W-1:0]  steps;
        logic [sms_pkg::PERIOD_W-1:0] half;
        logic                         rlim;
        logic                         llim;
        int                           roll;
        int                           pick;
        roll  = $urandom_range(99);
        dir   = 1'($urandom_range(1));
        steps = sms_pkg::STEPS_W'($urandom);
        half  = sms_pkg::PERIOD_W'($urandom);
        rlim  = 1'($urandom_range(1));
        llim  = 1'($urandom_range(1));
        if (!mv_active) begin
            if (roll < 75) begin
                kind = sms_pkg::KIND_START;
                pick = $urandom_range(99);
                if (pick < 80) begin
                    steps = sms_pkg::STEPS_W'($urandom_range(4));
                end else if (pick < 95) begin
                    steps = sms_pkg::STEPS_W'($urandom_range(40, 5));
                end
                pick = $urandom_range(99);
                if (pick < 70) begin
                    half = sms_pkg::PERIOD_W'($urandom_range(3, 1));
                end else if (pick < 80) begin
                    half = '0;
                end else if (pick < 95) begin
                    half = sms_pkg::PERIOD_W'($urandom_range(20, 4));
                end
                rlim = ($urandom_range(9) == 0);
                llim = ($urandom_range(9) == 0);
            end else begin
                kind = sms_pkg::KIND_W'($urandom_range(KIND_SPARE_LAST, sms_pkg::KIND_TICK));
            end
        end else begin
            if (roll < 80) begin
                kind = sms_pkg::KIND_TICK;
            end else if (roll < 86) begin
                kind = sms_pkg::KIND_RIGHT;
            end else if (roll < 92) begin
                kind = sms_pkg::KIND_LEFT;
            end else if (roll < 95) begin
                kind = sms_pkg::KIND_ESTOP;
            end else if (roll < 97) begin
                kind = sms_pkg::KIND_START;
            end else begin
                kind = sms_pkg::KIND_W'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
            end
        end
        send_item(kind, dir, steps, half, rlim, llim);
    endtask

    task automatic test_idle_items;
        send_item(sms_pkg::KIND_TICK, 1'b1, '1, '1, 1'b1, 1'b1);
        send_item(sms_pkg::KIND_RIGHT, 1'b1, '0, '0, 1'b1, 1'b0);
        send_item(sms_pkg::KIND_LEFT, 1'b0, '0, '0, 1'b0, 1'b1);
        send_item(sms_pkg::KIND_ESTOP, 1'b0, '0, '0, 1'b0, 1'b0);
        send_item(KIND_SPARE_LAST, 1'b1, '1, '1, 1'b1, 1'b1);
    endtask

    task automatic test_refused_starts;
        send_item(sms_pkg::KIND_START, 1'b1, 24'd5, 20'd1, 1'b1, 1'b0);
        send_item(sms_pkg::KIND_START, 1'b0, 24'd5, 20'd1, 1'b0, 1'b1);
        // The left switch does not block a move to the right.
        send_item(sms_pkg::KIND_START, 1'b1, '0, 20'd1, 1'b0, 1'b1);
    endtask

    task automatic test_short_moves;
        // A zero half-period behaves like one tick per toggle.
        send_item(sms_pkg::KIND_START, 1'b0, 24'd1, '0, 1'b0, 1'b0);
        send_item(sms_pkg::KIND_START, 1'b1, 24'd9, 20'd7, 1'b0, 1'b0);
        send_item(sms_pkg::KIND_TICK, 1'b0, '0, '0, 1'b0, 1'b0);
        send_item(sms_pkg::KIND_TICK, 1'b0, '0, '0, 1'b0, 1'b0);
    endtask

    task automatic test_limit_events;
        send_item(sms_pkg::KIND_START, 1'b1, '1, '1, 1'b0, 1'b0);
        send_item(sms_pkg::KIND_RIGHT, 1'b0, '0, '0, 1'b0, 1'b0);
        send_item(sms_pkg::KIND_LEFT, 1'b0, '0, '0, 1'b0, 1'b1);
        send_item(sms_pkg::KIND_RIGHT, 1'b0, '0, '0, 1'b1, 1'b0);
        send_item(sms_pkg::KIND_START, 1'b0, 24'd5, 20'd1, 1'b0, 1'b0);
        send_item(sms_pkg::KIND_TICK, 1'b0, '0, '0, 1'b0, 1'b0);
        send_item(sms_pkg::KIND_LEFT, 1'b0, '0, '0, 1'b0, 1'b1);
    endtask

    task automatic test_emergency_stop;
        send_item(sms_pkg::KIND_START, 1'b0, '1, '1, 1'b0, 1'b0);
        send_item(sms_pkg::KIND_ESTOP, 1'b0, '0, '0, 1'b0, 1'b0);
    endtask

    task automatic test_polarity(input logic right_high);
        write_polarity(right_high);
        send_item(sms_pkg::KIND_START, 1'b1, '0, 20'd1, 1'b0, 1'b0);
        send_item(sms_pkg::KIND_START, 1'b0, '0, 20'd1, 1'b0, 1'b0);
    endtask

    task automatic test_random_moves(input int count, input int idle_pct);
        tx_idle_pct = idle_pct;
        rx_idle_pct = idle_pct;
        repeat (count) send_random_item();
    endtask

    task automatic test_output_hold_off;
        // The output side stalls while items keep coming, so s_ready must drop.
        tx_idle_pct = 0;
        rx_idle_pct = 35;
        rx_hold_req = HOLD_OFF_CYCLES;
        repeat (120) send_random_item();
        wait_for_results();
    endtask

    always @(posedge aclk) begin
        if (aresetn !== 1'b1) begin
            m_ready <= 1'b0;
        end else if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
            m_ready <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            results_seen++;
            got_pins = {m_step_level, m_dir_level, m_enable_n, m_busy_res, m_done_res,
                        m_outcome};
            if (expected_pins.size() == 0) begin
                report_mismatch("result with nothing pending", 1, 0);
            end else begin
                want_pins = expected_pins.pop_front();
                if (got_pins.step_level !== want_pins.step_level)
                    report_mismatch("step_level", got_pins.step_level, want_pins.step_level);
                if (got_pins.dir_level !== want_pins.dir_level)
                    report_mismatch("dir_level", got_pins.dir_level, want_pins.dir_level);
                if (got_pins.enable_n !== want_pins.enable_n)
                    report_mismatch("enable_n", got_pins.enable_n, want_pins.enable_n);
                if (got_pins.busy_res !== want_pins.busy_res)
                    report_mismatch("busy_res", got_pins.busy_res, want_pins.busy_res);
                if (got_pins.done_res !== want_pins.done_res)
                    report_mismatch("done_res", got_pins.done_res, want_pins.done_res);
                if (got_pins.outcome !== want_pins.outcome)
                    report_mismatch("outcome", got_pins.outcome, want_pins.outcome);
                if (want_pins.done_res)
                    moves_ended[want_pins.outcome]++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid === 1'b1 && s_ready === 1'b1) ||
            (m_valid === 1'b1 && m_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_idle_items();
        test_refused_starts();
        test_short_moves();
        test_limit_events();
        test_emergency_stop();

        test_polarity(1'b0);
        test_random_moves(600, 35);
        test_output_hold_off();
        test_polarity(1'b1);
        test_random_moves(500, 0);
        test_polarity(1'b0);
        test_random_moves(400, 35);
        test_polarity(1'b1);
        test_random_moves(250, 35);

        wait_for_results();
        repeat (8) @(posedge aclk);
        if (expected_pins.size() != 0)
            report_mismatch("results never delivered", 0, expected_pins.size());
        $display("Sent %0d items and checked %0d results over both polarities, idle, no-idle",
                 items_sent, results_seen);
        $display("and hold-off phases; moves ended: %0d finished, %0d right, %0d left, %0d stop.",
                 moves_ended[sms_pkg::OUT_FINISHED], moves_ended[sms_pkg::OUT_RIGHT],
                 moves_ended[sms_pkg::OUT_LEFT], moves_ended[sms_pkg::OUT_ESTOP]);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
